/* src/wlo_pkg.sv */
// Shared types, constants and the control store for the wavetable oscillator.
`default_nettype none

package wlo_pkg;

  // Table and number formats.
  localparam int TABLE_DEPTH     = 1024;
  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_BITS      = 26;
  localparam int INDEX_BITS      = 10;
  localparam int ADDR_BITS       = $clog2(TABLE_DEPTH);

  // The phase fraction is used at 16 bits; S = 2^U_BITS is one in Q.16.
  localparam int U_BITS = 16;

  // Datapath widths.
  localparam int MUL_BITS   = 21;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  localparam int CHUNK_BITS = 20;
  localparam int W_BITS     = 2 * CHUNK_BITS;
  localparam int ACC_BITS   = 56;
  localparam int WGT_BITS   = 18;
  localparam int NUM_TAPS   = 4;
  localparam int TAP_BITS   = $clog2(NUM_TAPS);

  // Weight rounding: w = floor(floor((m + 3*2^32) / 2^33) / 3).
  // The divide by three is a multiply by ceil(2^21 / 3) and a shift by 21,
  // exact for dividends below 2^21.
  localparam int TQ_LSB      = 33;
  localparam int TQ_BITS     = 20;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_3     = ((1 << RECIP_SHIFT) + 2) / 3;
  localparam logic signed [ACC_BITS-1:0] WGT_BIAS = ACC_BITS'(3) <<< 32;

  // Program counter.
  localparam int PC_BITS = 5;

  typedef logic [PC_BITS-1:0] pc_t;

  // Input and output words.
  typedef struct packed {
    logic                          mode;
    logic [INDEX_BITS-1:0]         table_index;
    logic signed [SAMPLE_BITS-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          saturated;
  } out_item_t;

  // Word types on the input.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    MA_ZERO,
    MA_U,
    MA_A1,
    MA_A2,
    MA_A2X3,
    MA_V3,
    MA_TQ,
    MA_ENTRY
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_ZERO,
    MB_V,
    MB_A1,
    MB_WLO,
    MB_WHI,
    MB_RECIP,
    MB_WGT
  } mul_b_e;

  // Accumulator operations on the registered product.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ZERO,
    ACC_BIAS,
    ACC_ADD,
    ACC_ADD_HI,
    ACC_SUB
  } acc_op_e;

  // Sequencing.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BR_LOAD,
    SEQ_END
  } seq_op_e;

  // One control word of the program.
  typedef struct packed {
    mul_a_e                mul_a;
    mul_b_e                mul_b;
    acc_op_e               acc_op;
    logic                  w_load;
    logic                  wgt_load;
    logic [TAP_BITS-1:0]   wgt_idx;
    logic                  ram_rd;
    logic                  ram_wr;
    logic                  out_push;
    seq_op_e               seq;
    pc_t                   target;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    mul_a:    MA_ZERO,
    mul_b:    MB_ZERO,
    acc_op:   ACC_HOLD,
    w_load:   1'b0,
    wgt_load: 1'b0,
    wgt_idx:  '0,
    ram_rd:   1'b0,
    ram_wr:   1'b0,
    out_push: 1'b0,
    seq:      SEQ_NEXT,
    target:   '0
  };

  // Entry points of the program.
  localparam pc_t STEP_START = pc_t'(0);
  localparam pc_t STEP_LOAD  = pc_t'(27);

  // Tap order in the weight file.
  localparam logic [TAP_BITS-1:0] TAP_M1 = TAP_BITS'(0);
  localparam logic [TAP_BITS-1:0] TAP_0  = TAP_BITS'(1);
  localparam logic [TAP_BITS-1:0] TAP_P1 = TAP_BITS'(2);
  localparam logic [TAP_BITS-1:0] TAP_P2 = TAP_BITS'(3);

  // Control store. The multiplier result is registered, so a product that
  // is selected in one step is consumed by the accumulator in the next.
  // With u the fraction, v = S - u, a1 = S + u and a2 = 2S + u, the weight
  // magnitudes are a1*(u*v), 3*a2*(u*v), 3*v*(a2*a1) and u*(a2*a1); the
  // second factor of each is split into two 20-bit halves.
  function automatic ctrl_t ucode_word(input pc_t pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      // Dispatch on the word type and form u*v.
      5'd0: begin
        w.seq = SEQ_BR_LOAD;
        w.target = STEP_LOAD;
        w.mul_a = MA_U;
        w.mul_b = MB_V;
      end
      5'd1: begin
        w.w_load = 1'b1;
        w.acc_op = ACC_BIAS;
      end
      // Weight of the entry before the phase.
      5'd2: begin
        w.mul_a = MA_A1;
        w.mul_b = MB_WLO;
      end
      5'd3: begin
        w.acc_op = ACC_ADD;
        w.mul_a = MA_A1;
        w.mul_b = MB_WHI;
      end
      5'd4: w.acc_op = ACC_ADD_HI;
      5'd5: begin
        w.mul_a = MA_TQ;
        w.mul_b = MB_RECIP;
        w.acc_op = ACC_BIAS;
      end
      // Weight of the entry at the phase.
      5'd6: begin
        w.wgt_load = 1'b1;
        w.wgt_idx = TAP_M1;
        w.mul_a = MA_A2X3;
        w.mul_b = MB_WLO;
      end
      5'd7: begin
        w.acc_op = ACC_ADD;
        w.mul_a = MA_A2X3;
        w.mul_b = MB_WHI;
      end
      5'd8: w.acc_op = ACC_ADD_HI;
      5'd9: begin
        w.mul_a = MA_TQ;
        w.mul_b = MB_RECIP;
        w.acc_op = ACC_BIAS;
      end
      // Form a2*a1 for the two remaining weights.
      5'd10: begin
        w.wgt_load = 1'b1;
        w.wgt_idx = TAP_0;
        w.mul_a = MA_A2;
        w.mul_b = MB_A1;
      end
      5'd11: w.w_load = 1'b1;
      // Weight of the entry after the phase.
      5'd12: begin
        w.mul_a = MA_V3;
        w.mul_b = MB_WLO;
      end
      5'd13: begin
        w.acc_op = ACC_ADD;
        w.mul_a = MA_V3;
        w.mul_b = MB_WHI;
      end
      5'd14: w.acc_op = ACC_ADD_HI;
      5'd15: begin
        w.mul_a = MA_TQ;
        w.mul_b = MB_RECIP;
        w.acc_op = ACC_BIAS;
      end
      // Weight of the entry two after the phase.
      5'd16: begin
        w.wgt_load = 1'b1;
        w.wgt_idx = TAP_P1;
        w.mul_a = MA_U;
        w.mul_b = MB_WLO;
      end
      5'd17: begin
        w.acc_op = ACC_ADD;
        w.mul_a = MA_U;
        w.mul_b = MB_WHI;
      end
      5'd18: w.acc_op = ACC_ADD_HI;
      5'd19: begin
        w.mul_a = MA_TQ;
        w.mul_b = MB_RECIP;
        w.acc_op = ACC_ZERO;
      end
      // Read the four entries and form the weighted sum.
      5'd20: begin
        w.wgt_load = 1'b1;
        w.wgt_idx = TAP_P2;
        w.ram_rd = 1'b1;
      end
      5'd21: begin
        w.mul_a = MA_ENTRY;
        w.mul_b = MB_WGT;
        w.wgt_idx = TAP_M1;
        w.ram_rd = 1'b1;
      end
      5'd22: begin
        w.acc_op = ACC_ADD;
        w.mul_a = MA_ENTRY;
        w.mul_b = MB_WGT;
        w.wgt_idx = TAP_0;
        w.ram_rd = 1'b1;
      end
      5'd23: begin
        // The weight at the phase is negative.
        w.acc_op = ACC_SUB;
        w.mul_a = MA_ENTRY;
        w.mul_b = MB_WGT;
        w.wgt_idx = TAP_P1;
        w.ram_rd = 1'b1;
      end
      5'd24: begin
        w.acc_op = ACC_ADD;
        w.mul_a = MA_ENTRY;
        w.mul_b = MB_WGT;
        w.wgt_idx = TAP_P2;
      end
      5'd25: w.acc_op = ACC_ADD;
      // Round, saturate, hand off the result and advance the phase.
      5'd26: begin
        w.out_push = 1'b1;
        w.seq = SEQ_END;
      end
      // Table write.
      5'd27: begin
        w.ram_wr = 1'b1;
        w.seq = SEQ_END;
      end
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/wlo_ram.sv */
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module wlo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/wlo_sequencer.sv */
// Program counter and control store of the oscillator.
`default_nettype none

module wlo_sequencer
  import wlo_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic mode_i,
  input  wire logic out_free_i,
  output logic      busy_o,
  output ctrl_t     ctrl_o
);

  logic  busy_q, busy_d;
  pc_t   pc_q, pc_d;
  ctrl_t word;
  logic  stall;

  // Fetch the current control word; an idle sequencer issues no work.
  always_comb begin
    word   = ucode_word(pc_q);
    ctrl_o = busy_q ? word : CTRL_NOP;
  end

  // A result step waits while the output register is still full.
  assign stall = ctrl_o.out_push && !out_free_i;

  // Next program counter.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = STEP_START;
      end
    end else if (!stall) begin
      unique case (ctrl_o.seq)
        SEQ_NEXT:    pc_d = pc_q + pc_t'(1);
        SEQ_BR_LOAD: pc_d = (mode_i == MODE_TICK) ? pc_q + pc_t'(1) : ctrl_o.target;
        SEQ_END:     busy_d = 1'b0;
        default:     busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= STEP_START;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

/* src/wlo_datapath.sv */
// Shared multiplier, accumulator and weight file of the interpolator.
`default_nettype none

module wlo_datapath
  import wlo_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ctrl_t                  ctrl_i,
  input  wire logic [U_BITS-1:0]      frac_i,
  input  wire logic [SAMPLE_BITS-1:0] entry_i,
  output out_item_t                   result_o
);

  localparam logic signed [ACC_BITS-1:0] SAMPLE_MAX =
    (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] HALF_UP    = ACC_BITS'(1) <<< (U_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] HALF_DOWN  = HALF_UP - ACC_BITS'(1);

  logic [U_BITS:0]   v_val;
  logic [U_BITS:0]   a1_val;
  logic [U_BITS+1:0] a2_val;
  logic [U_BITS+3:0] a2x3_val;
  logic [U_BITS+1:0] v3_val;
  logic [TQ_BITS-1:0] tq;

  logic signed [MUL_BITS-1:0]  mul_a, mul_b;
  logic signed [PROD_BITS-1:0] prod_q, prod_d;
  logic signed [ACC_BITS-1:0]  acc_q, acc_d;
  logic [W_BITS-1:0]           w_q;
  logic [WGT_BITS-1:0]         wgt_q [NUM_TAPS];
  logic signed [ACC_BITS-1:0]  rounded, y_val;

  // Factors of the Lagrange basis.
  assign v_val    = (U_BITS+1)'(1) << U_BITS;
  assign a1_val   = {1'b1, frac_i};
  assign a2_val   = {2'b10, frac_i};
  assign a2x3_val = (U_BITS+4)'(a2_val) + ((U_BITS+4)'(a2_val) << 1);
  assign v3_val   = (U_BITS+2)'(v_val - (U_BITS+1)'(frac_i)) * (U_BITS+2)'(3);
  assign tq       = acc_q[TQ_LSB +: TQ_BITS];

  // Operand selection.
  always_comb begin
    unique case (ctrl_i.mul_a)
      MA_ZERO:  mul_a = '0;
      MA_U:     mul_a = MUL_BITS'(frac_i);
      MA_A1:    mul_a = MUL_BITS'(a1_val);
      MA_A2:    mul_a = MUL_BITS'(a2_val);
      MA_A2X3:  mul_a = MUL_BITS'(a2x3_val);
      MA_V3:    mul_a = MUL_BITS'(v3_val);
      MA_TQ:    mul_a = MUL_BITS'(tq);
      MA_ENTRY: mul_a = MUL_BITS'(signed'(entry_i));
      default:  mul_a = '0;
    endcase
    unique case (ctrl_i.mul_b)
      MB_ZERO:  mul_b = '0;
      MB_V:     mul_b = MUL_BITS'(v_val - (U_BITS+1)'(frac_i));
      MB_A1:    mul_b = MUL_BITS'(a1_val);
      MB_WLO:   mul_b = MUL_BITS'(w_q[CHUNK_BITS-1:0]);
      MB_WHI:   mul_b = MUL_BITS'(w_q[W_BITS-1:CHUNK_BITS]);
      MB_RECIP: mul_b = MUL_BITS'(RECIP_3);
      MB_WGT:   mul_b = MUL_BITS'(wgt_q[ctrl_i.wgt_idx]);
      default:  mul_b = '0;
    endcase
  end

  // The one multiplier, registered.
  assign prod_d = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // Accumulator.
  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_HOLD:   acc_d = acc_q;
      ACC_ZERO:   acc_d = '0;
      ACC_BIAS:   acc_d = WGT_BIAS;
      ACC_ADD:    acc_d = acc_q + ACC_BITS'(prod_q);
      ACC_ADD_HI: acc_d = acc_q + (ACC_BITS'(prod_q) <<< CHUNK_BITS);
      ACC_SUB:    acc_d = acc_q - ACC_BITS'(prod_q);
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Product, partial-product operand and weight registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.w_load) begin
      w_q <= prod_q[W_BITS-1:0];
    end
    if (ctrl_i.wgt_load) begin
      wgt_q[ctrl_i.wgt_idx] <= prod_q[RECIP_SHIFT +: WGT_BITS];
    end
  end

  // Divide by S with halves rounded away from zero, then saturate.
  assign rounded = acc_q + (acc_q[ACC_BITS-1] ? HALF_DOWN : HALF_UP);
  assign y_val   = rounded >>> U_BITS;

  always_comb begin
    if (y_val > SAMPLE_MAX) begin
      result_o.sample    = SAMPLE_MAX[SAMPLE_BITS-1:0];
      result_o.saturated = 1'b1;
    end else if (y_val < SAMPLE_MIN) begin
      result_o.sample    = SAMPLE_MIN[SAMPLE_BITS-1:0];
      result_o.saturated = 1'b1;
    end else begin
      result_o.sample    = y_val[SAMPLE_BITS-1:0];
      result_o.saturated = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* src/wavetable_lagrange_oscillator_unit.sv */
// Top level of the wavetable oscillator with four-point Lagrange interpolation.
// Each word runs the program of one shared multiplier: 27 control steps per
// tick, 2 per load. No new word is taken until the program of the last has
// ended; the result step waits while the output register is full and unread.
// The input is taken while an earlier result still waits in the output register.
// Reset clears control, the phase and the phase step; table contents stay unknown.
`default_nettype none

module wavetable_lagrange_oscillator_unit
  import wlo_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [PHASE_BITS-1:0] cfg_phase_step_i
);

  localparam logic [PHASE_BITS:0] PHASE_SPAN =
    (PHASE_BITS+1)'(TABLE_DEPTH) << PHASE_FRAC_BITS;
  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TABLE_DEPTH - 1);

  logic                  busy;
  logic                  in_accept;
  logic                  out_free;
  logic                  push;
  ctrl_t                 ctrl;
  in_item_t              item_q;
  logic [PHASE_BITS-1:0] phase_step_q;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS:0]   phase_sum;
  logic [ADDR_BITS-1:0]  int_phase, start_addr;
  logic [ADDR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic                  wr_en;
  logic [SAMPLE_BITS-1:0] entry;
  out_item_t             result;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  // Input and configuration handshakes.
  assign in_ready_o  = !busy;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      phase_step_q <= cfg_phase_step_i;
    end
  end

  // Output slot is free when empty or being emptied this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  assign push     = ctrl.out_push && out_free;

  wlo_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .mode_i     (item_q.mode),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  // Phase advance with wrap at the table length.
  assign phase_sum = (PHASE_BITS+1)'(phase_q) + (PHASE_BITS+1)'(phase_step_q);

  always_comb begin
    if (phase_sum >= PHASE_SPAN) begin
      phase_d = PHASE_BITS'(phase_sum - PHASE_SPAN);
    end else begin
      phase_d = PHASE_BITS'(phase_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (push) begin
      phase_q <= phase_d;
    end
  end

  // Read pointer starts one entry before the phase and steps with wrap.
  assign int_phase  = phase_q[PHASE_BITS-1:PHASE_FRAC_BITS];
  assign start_addr = (int_phase == '0) ? LAST_ADDR : int_phase - ADDR_BITS'(1);

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (in_accept) begin
      rd_ptr_d = start_addr;
    end else if (ctrl.ram_rd) begin
      rd_ptr_d = (rd_ptr_q == LAST_ADDR) ? '0 : rd_ptr_q + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Table store; writes beyond the table are dropped.
  assign wr_en = ctrl.ram_wr && ((INDEX_BITS+1)'(item_q.table_index) <
                                 (INDEX_BITS+1)'(TABLE_DEPTH));

  wlo_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_BITS'(item_q.table_index)),
    .wdata_i (item_q.table_value),
    .re_i    (ctrl.ram_rd),
    .raddr_i (rd_ptr_q),
    .rdata_o (entry)
  );

  wlo_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .frac_i   (phase_q[PHASE_FRAC_BITS-1 -: U_BITS]),
    .entry_i  (entry),
    .result_o (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
